[hw/rtl/lpfd_pkg.sv]
`timescale 1ns / 1ps
// lpfd_pkg: types, constants and codes shared by the frame deframer modules
// no dependencies

package lpfd_pkg;

	// handle store and frame limits
	localparam int HFIFO_DEPTH     = 32;
	localparam int HPTR_W          = $clog2(HFIFO_DEPTH);
	localparam int HLVL_W          = HPTR_W + 1;
	localparam int HCNT_W          = 5;
	localparam int DEF_MAX_HANDLES = 16;

	// header layout
	localparam int HDR_BYTES  = 8;
	localparam int HDR_CNT_W  = $clog2(HDR_BYTES);
	localparam int HDR_KEEP_W = (HDR_BYTES - 1) * 8;

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = CQ_PTR_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [31:0]       RESET_MAX_BODY  = 32'd1048576;
	localparam logic [HCNT_W-1:0] RESET_MAX_FRAME = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BODY    = 1'b0,
		REG_MAX_HANDLES = 1'b1
	} cfg_reg_t;

	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_HANDLE = 1'b1;

	typedef enum logic [1:0] {
		KIND_BODY   = 2'd0,
		KIND_HANDLE = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_OVERSIZE = 2'd0,
		ERR_TOO_MANY = 2'd1,
		ERR_MISMATCH = 2'd2
	} err_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  data_byte;
		logic [31:0] handle;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  body_byte;
		logic [31:0] out_handle;
		err_t        error_code;
		logic        last;
	} result_t;

	// work handed from front to back
	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TAIL  = 2'd2,
		CMD_ERROR = 2'd3
	} cmd_op_t;

	typedef enum logic [1:0] {
		TAIL_NONE     = 2'd0,
		TAIL_END      = 2'd1,
		TAIL_MISMATCH = 2'd2
	} tail_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [31:0]       data;
		err_t              code;
		tail_t             tail;
		logic [HCNT_W-1:0] count;
	} cmd_t;

	typedef enum logic [2:0] {
		B_CMD      = 3'd0,
		B_READ     = 3'd1,
		B_EMIT     = 3'd2,
		B_END      = 3'd3,
		B_MISMATCH = 3'd4
	} back_state_t;

endpackage

[hw/rtl/length_prefixed_frame_deframer_top.sv]
`timescale 1ns / 1ps
// length_prefixed_frame_deframer_top: length-prefixed frame deframer with handle queue
// depends on lpfd_pkg, lpfd_front, lpfd_cmdq, lpfd_back
//
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   lpfd_pkg::item_t (op, data_byte, handle)
// result    out        result_valid / result_stall lpfd_pkg::result_t
// config    in         cfg_we, cfg_index         cfg_data (32 bits)
//
// a word is taken at a rising edge with valid high and stall low
// stream bytes and handle words go in one per cycle while the command queue has room;
// body bytes come out one per cycle while result_stall is low and no drain is running
// a frame's drain: per handle a registered read of the handle store, then an emit, then
// the end marker; the front accepts during the drain until the 4-entry command queue fills
// reset is asynchronous, active low; the handle store needs no clearing pass

module length_prefixed_frame_deframer_top #(
	parameter int MAX_HANDLES = lpfd_pkg::DEF_MAX_HANDLES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	input  lpfd_pkg::item_t                 item,
	output logic                            item_stall,
	output logic                            result_valid,
	output lpfd_pkg::result_t               result,
	input  logic                            result_stall
);
	import lpfd_pkg::*;

	// front to queue
	cmd_t    cmd_front;
	logic    cq_push;
	logic    cq_full;

	// queue to back
	logic    head_valid;
	cmd_t    head;
	logic    head_pop;

	// header parsing, limit checks and handle occupancy live in the front
	lpfd_front #(
		.MAX_HANDLES(MAX_HANDLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item      (item),
		.item_stall(item_stall),
		.cmd       (cmd_front),
		.cq_push   (cq_push),
		.cq_full   (cq_full)
	);

	// decouples front and back so a handle drain does not stall the stream at once
	lpfd_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_front),
		.push      (cq_push),
		.full      (cq_full),
		.pop       (head_pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// handle store, drain sequencer and the result register
	lpfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (head_valid),
		.cmd         (head),
		.cmd_pop     (head_pop),
		.result_valid(result_valid),
		.result      (result),
		.result_stall(result_stall)
	);

endmodule

[hw/rtl/lpfd_front.sv]
`timescale 1ns / 1ps
// lpfd_front: accepts words, parses headers, tracks handle occupancy, issues commands
// depends on lpfd_pkg

module lpfd_front #(
	parameter int MAX_HANDLES = lpfd_pkg::DEF_MAX_HANDLES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	input  lpfd_pkg::item_t                 item,
	output logic                            item_stall,
	output lpfd_pkg::cmd_t                  cmd,
	output logic                            cq_push,
	input  logic                            cq_full
);
	import lpfd_pkg::*;

	logic [31:0]           max_body_q;
	logic [HCNT_W-1:0]     max_frame_q;
	logic [HDR_KEEP_W-1:0] hdr_q;
	logic [HDR_CNT_W-1:0]  hcnt_q, hcnt_n;
	logic [31:0]           body_q, body_n;
	logic [HCNT_W-1:0]     frame_cnt_q, frame_n;
	logic [HLVL_W-1:0]     level_q, level_n;
	logic                  failed_q, failed_n;

	logic                  accept, push;
	logic                  hdr_wr, hdr_clr;
	logic                  finish;
	logic [HCNT_W-1:0]     fin_cnt;
	logic [HCNT_W-1:0]     lim;
	logic [HLVL_W-1:0]     dbl, bound;
	logic [31:0]           hdr_len, hdr_cnt;

	assign item_stall = cq_full;
	assign accept     = item_valid & ~cq_full;
	assign cq_push    = push;

	// effective per-frame limit and store flood bound
	always_comb begin
		if (max_frame_q > HCNT_W'(MAX_HANDLES))
			lim = HCNT_W'(MAX_HANDLES);
		else
			lim = max_frame_q;
		dbl = {lim, 1'b0};
		if (dbl > HLVL_W'(HFIFO_DEPTH))
			bound = HLVL_W'(HFIFO_DEPTH);
		else
			bound = dbl;
	end

	assign hdr_len = hdr_q[31:0];
	assign hdr_cnt = {item.data_byte, hdr_q[HDR_KEEP_W-1:32]};

	always_comb begin
		cmd.op    = CMD_TAIL;
		cmd.data  = '0;
		cmd.code  = ERR_OVERSIZE;
		cmd.tail  = TAIL_NONE;
		cmd.count = '0;
		push      = 1'b0;
		level_n   = level_q;
		frame_n   = frame_cnt_q;
		body_n    = body_q;
		hcnt_n    = hcnt_q;
		failed_n  = failed_q;
		hdr_wr    = 1'b0;
		hdr_clr   = 1'b0;
		finish    = 1'b0;
		fin_cnt   = frame_cnt_q;
		if (accept && !failed_q) begin
			if (item.op == OP_HANDLE) begin
				push = 1'b1;
				if (level_q >= bound) begin
					cmd.op   = CMD_ERROR;
					cmd.code = ERR_TOO_MANY;
					failed_n = 1'b1;
				end else begin
					cmd.op   = CMD_PUSH;
					cmd.data = item.handle;
					level_n  = level_q + 1'b1;
				end
			end else if (body_q != '0) begin
				push     = 1'b1;
				cmd.op   = CMD_BYTE;
				cmd.data = {24'd0, item.data_byte};
				body_n   = body_q - 1'b1;
				finish   = (body_q == 32'd1);
			end else if (hcnt_q == HDR_CNT_W'(HDR_BYTES - 1)) begin
				hdr_clr = 1'b1;
				hcnt_n  = '0;
				if (hdr_len > max_body_q) begin
					push     = 1'b1;
					cmd.op   = CMD_ERROR;
					cmd.code = ERR_OVERSIZE;
					failed_n = 1'b1;
				end else if (hdr_cnt > 32'(lim)) begin
					push     = 1'b1;
					cmd.op   = CMD_ERROR;
					cmd.code = ERR_TOO_MANY;
					failed_n = 1'b1;
				end else begin
					frame_n = hdr_cnt[HCNT_W-1:0];
					body_n  = hdr_len;
					fin_cnt = hdr_cnt[HCNT_W-1:0];
					if (hdr_len == '0) begin
						push   = 1'b1;
						cmd.op = CMD_TAIL;
						finish = 1'b1;
					end
				end
			end else begin
				hdr_wr = 1'b1;
				hcnt_n = hcnt_q + 1'b1;
			end

			// frame completion: enough handles queued or not
			if (finish) begin
				if (HLVL_W'(fin_cnt) > level_q) begin
					cmd.tail = TAIL_MISMATCH;
					failed_n = 1'b1;
				end else begin
					cmd.tail  = TAIL_END;
					cmd.count = fin_cnt;
					level_n   = level_q - HLVL_W'(fin_cnt);
					frame_n   = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q  <= RESET_MAX_BODY;
			max_frame_q <= RESET_MAX_FRAME;
			hdr_q       <= '0;
			hcnt_q      <= '0;
			body_q      <= '0;
			frame_cnt_q <= '0;
			level_q     <= '0;
			failed_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAX_BODY:    max_body_q  <= cfg_data;
					REG_MAX_HANDLES: max_frame_q <= cfg_data[HCNT_W-1:0];
					default: ;
				endcase
			end
			if (hdr_clr) begin
				hdr_q <= '0;
			end else if (hdr_wr) begin
				for (int i = 0; i < HDR_BYTES - 1; i++) begin
					if (hcnt_q == HDR_CNT_W'(i))
						hdr_q[i*8 +: 8] <= item.data_byte;
				end
			end
			hcnt_q      <= hcnt_n;
			body_q      <= body_n;
			frame_cnt_q <= frame_n;
			level_q     <= level_n;
			failed_q    <= failed_n;
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= HLVL_W'(HFIFO_DEPTH))
		else $error("handle occupancy beyond store depth");

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q && !cq_push)
		else $error("failed state left or command issued after failure");

endmodule

[hw/rtl/lpfd_cmdq.sv]
`timescale 1ns / 1ps
// lpfd_cmdq: short command queue between the front and back parts
// depends on lpfd_pkg

module lpfd_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  lpfd_pkg::cmd_t cmd_in,
	input  logic           push,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output lpfd_pkg::cmd_t head
);
	import lpfd_pkg::*;

	cmd_t                slot_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wp_q, rp_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_push, do_pop;

	assign full       = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rp_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wp_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

endmodule

[hw/rtl/lpfd_back.sv]
`timescale 1ns / 1ps
// lpfd_back: executes commands, owns the handle store and the result register
// depends on lpfd_pkg

module lpfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  lpfd_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              result_valid,
	output lpfd_pkg::result_t result,
	input  logic              result_stall
);
	import lpfd_pkg::*;

	logic [31:0]       hmem [HFIFO_DEPTH];
	logic [31:0]       rdata_q;
	logic [HPTR_W-1:0] wp_q, rp_q;
	logic [HCNT_W-1:0] remain_q, remain_n;
	back_state_t       state_q, state_n;
	result_t           res_q, res_n;
	logic              res_valid_q;
	logic              out_free, load, mem_we, rd_en;

	assign out_free     = ~res_valid_q | ~result_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		state_n  = state_q;
		remain_n = remain_q;
		cmd_pop  = 1'b0;
		load     = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		res_n    = '{kind: KIND_BODY, body_byte: 8'd0, out_handle: 32'd0,
			error_code: ERR_OVERSIZE, last: 1'b0};
		case (state_q)
			B_CMD: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						CMD_PUSH: mem_we = 1'b1;
						CMD_BYTE: begin
							load            = 1'b1;
							res_n.kind      = KIND_BODY;
							res_n.body_byte = cmd.data[7:0];
						end
						CMD_ERROR: begin
							load             = 1'b1;
							res_n.kind       = KIND_ERROR;
							res_n.error_code = cmd.code;
							res_n.last       = 1'b1;
						end
						default: ;
					endcase
					remain_n = cmd.count;
					case (cmd.tail)
						TAIL_END:      state_n = (cmd.count != '0) ? B_READ : B_END;
						TAIL_MISMATCH: state_n = B_MISMATCH;
						default:       state_n = B_CMD;
					endcase
				end
			end
			B_READ: begin
				rd_en    = 1'b1;
				remain_n = remain_q - 1'b1;
				state_n  = B_EMIT;
			end
			B_EMIT: begin
				if (out_free) begin
					load             = 1'b1;
					res_n.kind       = KIND_HANDLE;
					res_n.out_handle = rdata_q;
					state_n          = (remain_q == '0) ? B_END : B_READ;
				end
			end
			B_END: begin
				if (out_free) begin
					load       = 1'b1;
					res_n.kind = KIND_END;
					res_n.last = 1'b1;
					state_n    = B_CMD;
				end
			end
			B_MISMATCH: begin
				if (out_free) begin
					load             = 1'b1;
					res_n.kind       = KIND_ERROR;
					res_n.error_code = ERR_MISMATCH;
					res_n.last       = 1'b1;
					state_n          = B_CMD;
				end
			end
			default: state_n = B_CMD;
		endcase
	end

	// handle store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			hmem[wp_q] <= cmd.data;
		if (rd_en)
			rdata_q <= hmem[rp_q];
		if (load)
			res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CMD;
			remain_q    <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			remain_q <= remain_n;
			if (mem_we)
				wp_q <= wp_q + 1'b1;
			if (rd_en)
				rp_q <= rp_q + 1'b1;
			if (load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	a_read_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |=> (state_q == B_EMIT))
		else $error("handle read not followed by emit");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the length-prefixed frame deframer
// depends on lpfd_pkg and length_prefixed_frame_deframer_top; a local predictor checks results

module tb_top;
	import lpfd_pkg::*;

	// consecutive cycles with no word moving on either channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 4000;
	// the back sequencer may still drain the command queue after the last result
	localparam int SETTLE_CYCLES  = 64;
	localparam int TAIL_CYCLES    = 100;
	localparam int RANDOM_WORDS   = 60;

	// which illegal sequence ends the run (errors are sticky, so only one per run)
	typedef enum int {
		BREAK_OVERSIZE,
		BREAK_COUNT,
		BREAK_FLOOD,
		BREAK_MISMATCH
	} break_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	item_t                 item;
	logic                  item_stall;
	logic                  result_valid;
	result_t               result;
	logic                  result_stall;

	length_prefixed_frame_deframer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item         (item),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// deframer predictor: its own copy of registers and frame state
	// ---------------------------------------------------------------
	logic [31:0]       m_max_body;
	logic [HCNT_W-1:0] m_max_frame;
	logic [63:0]       m_hdr;
	int unsigned       m_hdr_n;
	logic [31:0]       m_body_left;
	logic [HCNT_W-1:0] m_frame_cnt;
	logic [31:0]       m_hfifo [HFIFO_DEPTH];
	int unsigned       m_level;
	logic [HPTR_W-1:0] m_rd;
	logic [HPTR_W-1:0] m_wr;
	bit                m_failed;

	// results predicted but not yet seen on the result channel
	result_t pending_results [$];
	result_t want_res;

	int unsigned words_sent;
	int unsigned results_seen;
	int unsigned frames_sent;
	int unsigned reg_writes;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	bit          tx_quiet;
	bit          rx_quiet;
	break_t      break_case;

	task automatic clear_deframe_state();
		m_max_body  = RESET_MAX_BODY;
		m_max_frame = RESET_MAX_FRAME;
		m_hdr       = '0;
		m_hdr_n     = 0;
		m_body_left = '0;
		m_frame_cnt = '0;
		m_level     = 0;
		m_rd        = '0;
		m_wr        = '0;
		m_failed    = 1'b0;
	endtask

	// per-frame handle limit: register value capped at the build parameter
	function automatic int unsigned handle_limit();
		return (m_max_frame > DEF_MAX_HANDLES) ? DEF_MAX_HANDLES : int'(m_max_frame);
	endfunction

	task automatic expect_result(kind_t k, logic [7:0] b, logic [31:0] h, err_t c, logic l);
		result_t r;
		r.kind       = k;
		r.body_byte  = b;
		r.out_handle = h;
		r.error_code = c;
		r.last       = l;
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic expect_error(err_t c);
		expect_result(KIND_ERROR, 8'h00, 32'h0, c, 1'b1);
		m_failed = 1'b1;
	endtask

	// frame done: pop its declared handles then the end marker, or flag a shortfall
	task automatic expect_frame_done();
		if (m_level < m_frame_cnt) begin
			expect_error(ERR_MISMATCH);
		end else begin
			repeat (m_frame_cnt) begin
				expect_result(KIND_HANDLE, 8'h00, m_hfifo[m_rd], ERR_OVERSIZE, 1'b0);
				m_rd    = m_rd + 1'b1;
				m_level = m_level - 1;
			end
			m_frame_cnt = '0;
			expect_result(KIND_END, 8'h00, 32'h0, ERR_OVERSIZE, 1'b1);
		end
	endtask

	task automatic deframe_step(item_t w);
		logic [31:0] len;
		logic [31:0] cnt;
		int unsigned bound;
		if (m_failed)
			return;
		if (w.op == OP_HANDLE) begin
			bound = 2 * handle_limit();
			if (bound > HFIFO_DEPTH)
				bound = HFIFO_DEPTH;
			if (m_level >= bound) begin
				expect_error(ERR_TOO_MANY);
				return;
			end
			m_hfifo[m_wr] = w.handle;
			m_wr          = m_wr + 1'b1;
			m_level       = m_level + 1;
			return;
		end
		if (m_body_left != 0) begin
			expect_result(KIND_BODY, w.data_byte, 32'h0, ERR_OVERSIZE, 1'b0);
			m_body_left = m_body_left - 1;
			if (m_body_left == 0)
				expect_frame_done();
			return;
		end
		m_hdr   = m_hdr | (64'(w.data_byte) << (8 * m_hdr_n));
		m_hdr_n = m_hdr_n + 1;
		if (m_hdr_n >= HDR_BYTES) begin
			len     = m_hdr[31:0];
			cnt     = m_hdr[63:32];
			m_hdr   = '0;
			m_hdr_n = 0;
			if (len > m_max_body) begin
				expect_error(ERR_OVERSIZE);
			end else if (cnt > handle_limit()) begin
				expect_error(ERR_TOO_MANY);
			end else begin
				m_frame_cnt = cnt[HCNT_W-1:0];
				m_body_left = len;
				if (len == 0)
					expect_frame_done();
			end
		end
	endtask

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_handle();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0000_0000;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// handle word with junk in the unused byte field
	function automatic item_t make_handle_word();
		item_t w;
		w.op        = OP_HANDLE;
		w.data_byte = 8'($urandom);
		w.handle    = pick_handle();
		return w;
	endfunction

	// one word on the item channel; valid stays high into the next send when the gap is zero
	task automatic send_word(item_t w);
		int unsigned gap;
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		deframe_step(w);
		words_sent = words_sent + 1;
		gap = pick_gap(tx_quiet);
		if (gap != 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic go_idle();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// hold the sender until every predicted result is out, then let the back end settle
	task automatic wait_results_drained();
		go_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		wait_results_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_BODY)
			m_max_body = val;
		else
			m_max_frame = val[HCNT_W-1:0];
		reg_writes = reg_writes + 1;
	endtask

	// header (len, cnt little-endian), then body; handle words fall at random points before
	// the final stream byte; fill < 0 means random body bytes
	task automatic send_frame(logic [31:0] len, logic [31:0] cnt, int unsigned n_handles,
			int fill, bit hdr_only);
		int unsigned total;
		int unsigned left;
		int unsigned j;
		item_t       w;
		total = hdr_only ? HDR_BYTES : HDR_BYTES + len;
		left  = n_handles;
		for (j = 0; j < total; j++) begin
			while (left != 0 && (j == total - 1 || $urandom_range(0, 3) == 0)) begin
				send_word(make_handle_word());
				left = left - 1;
			end
			w.op     = OP_BYTE;
			w.handle = $urandom;
			if (j < 4)
				w.data_byte = len[8*j +: 8];
			else if (j < 8)
				w.data_byte = cnt[8*(j-4) +: 8];
			else if (fill >= 0)
				w.data_byte = fill[7:0];
			else
				w.data_byte = pick_byte();
			send_word(w);
		end
		frames_sent = frames_sent + 1;
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// empty body completes on the last header byte, with and without handles
	task automatic test_empty_frames();
		send_frame(0, 0, 0, -1, 1'b0);
		send_frame(0, 2, 2, -1, 1'b0);
	endtask

	// body bytes at both ends of the byte range
	task automatic test_byte_extremes();
		send_frame(1, 0, 0, 8'h00, 1'b0);
		send_frame(1, 1, 1, 8'hFF, 1'b0);
	endtask

	// sixteen handles on one frame: the longest burst of results one word can cause
	task automatic test_max_handles();
		rx_quiet = 1'b0;
		send_frame(1, DEF_MAX_HANDLES, DEF_MAX_HANDLES, -1, 1'b0);
	endtask

	// both registers at their extremes; junk above bit 4 of the handle limit is dropped
	task automatic test_register_extremes();
		write_reg(REG_MAX_BODY, 32'h0);
		send_frame(0, 1, 1, -1, 1'b0);
		write_reg(REG_MAX_BODY, 32'hFFFF_FFFF);
		send_frame(5, 2, 2, -1, 1'b0);
		// body exactly at the limit is legal
		write_reg(REG_MAX_BODY, 32'd3);
		send_frame(3, 1, 1, -1, 1'b0);
		write_reg(REG_MAX_HANDLES, $urandom & 32'hFFFF_FFE0);
		send_frame(2, 0, 0, -1, 1'b0);
		// register above the build limit is capped
		write_reg(REG_MAX_HANDLES, ($urandom & 32'hFFFF_FFE0) | 32'd31);
		send_frame(1, DEF_MAX_HANDLES, DEF_MAX_HANDLES, -1, 1'b0);
		write_reg(REG_MAX_HANDLES, ($urandom & 32'hFFFF_FFE0) | 32'd1);
		send_frame(0, 1, 1, -1, 1'b0);
		write_reg(REG_MAX_BODY, RESET_MAX_BODY);
		write_reg(REG_MAX_HANDLES, 32'(RESET_MAX_FRAME));
	endtask

	// well-formed frames with random content, settings and idling
	task automatic test_random_frames();
		int unsigned stop_at;
		int unsigned lim;
		int unsigned cap;
		int unsigned len;
		int unsigned cnt;
		int unsigned r;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0) begin
				r = $urandom_range(0, 4);
				case (r)
					0: begin
						write_reg(REG_MAX_BODY, 32'h0);
					end
					1: begin
						write_reg(REG_MAX_BODY, 32'hFFFF_FFFF);
					end
					2: begin
						write_reg(REG_MAX_BODY, $urandom_range(1, 8));
					end
					default: begin
						write_reg(REG_MAX_BODY, $urandom);
					end
				endcase
				if ($urandom_range(0, 3) == 0)
					write_reg(REG_MAX_HANDLES, 32'(DEF_MAX_HANDLES));
				else
					write_reg(REG_MAX_HANDLES, $urandom);
			end
			if ($urandom_range(0, 4) == 0)
				tx_quiet = !tx_quiet;
			if ($urandom_range(0, 4) == 0)
				rx_quiet = !rx_quiet;
			// sender holds until the block has emptied
			if ($urandom_range(0, 14) == 0)
				wait_results_drained();
			lim = handle_limit();
			cap = (m_max_body < 24) ? m_max_body : 24;
			if ($urandom_range(0, 3) != 0)
				len = $urandom_range(0, (cap < 6) ? cap : 6);
			else
				len = $urandom_range(0, cap);
			if (lim == 0)
				cnt = 0;
			else if ($urandom_range(0, 5) == 0)
				cnt = lim;
			else
				cnt = $urandom_range(0, lim);
			send_frame(len, cnt, cnt, -1, 1'b0);
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// one illegal sequence, then noise that a failed block must swallow silently
	task automatic test_sticky_error();
		int unsigned cnt;
		item_t       w;
		break_case = break_t'($urandom_range(0, 3));
		case (break_case)
			BREAK_OVERSIZE: begin
				if (m_max_body == 32'hFFFF_FFFF)
					write_reg(REG_MAX_BODY, $urandom_range(0, 20));
				send_frame(($urandom_range(0, 1) != 0) ? m_max_body + 32'd1 : 32'hFFFF_FFFF,
					0, 0, -1, 1'b1);
			end
			BREAK_COUNT: begin
				send_frame(0, ($urandom_range(0, 1) != 0) ? 32'(handle_limit() + 1)
					: ($urandom | 32'h0000_0100), 0, -1, 1'b1);
			end
			BREAK_FLOOD: begin
				// one handle past twice the frame limit
				repeat (2 * handle_limit() + 1) send_word(make_handle_word());
			end
			default: begin
				if (handle_limit() == 0)
					write_reg(REG_MAX_HANDLES, 32'd4);
				cnt = $urandom_range(1, handle_limit());
				send_frame($urandom_range(0, 4), cnt, cnt - 1, -1, 1'b0);
			end
		endcase
		repeat (20) begin
			w.op        = 1'($urandom_range(0, 1));
			w.data_byte = 8'($urandom);
			w.handle    = $urandom;
			send_word(w);
		end
	endtask

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------
	task automatic flag_mismatch(string what);
		mismatches = mismatches + 1;
		$display("tb_top: mismatch at %0t ns: %s", $realtime, what);
	endtask

	// every accepted result word is compared with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen = results_seen + 1;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result with none expected: kind %0d", result.kind));
			end else begin
				want_res = pending_results[0];
				pending_results.delete(0);
				if (result.kind !== want_res.kind)
					flag_mismatch($sformatf("kind %0d, expected %0d",
						result.kind, want_res.kind));
				if (result.body_byte !== want_res.body_byte)
					flag_mismatch($sformatf("body_byte %h, expected %h",
						result.body_byte, want_res.body_byte));
				if (result.out_handle !== want_res.out_handle)
					flag_mismatch($sformatf("out_handle %h, expected %h",
						result.out_handle, want_res.out_handle));
				if (result.error_code !== want_res.error_code)
					flag_mismatch($sformatf("error_code %0d, expected %0d",
						result.error_code, want_res.error_code));
				if (result.last !== want_res.last)
					flag_mismatch($sformatf("last %b, expected %b",
						result.last, want_res.last));
			end
		end
	end

	// watchdog: a stuck handshake on either side ends the run
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: watchdog, no word moved for %0d cycles, %0d results pending",
					quiet_cycles, pending_results.size());
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// receiver backpressure: stall runs of random length, none while rx_quiet is set
	initial begin
		int unsigned n;
		int unsigned m;
		@(posedge arst_n);
		forever begin
			n = pick_gap(rx_quiet);
			repeat (n) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
			m = $urandom_range(1, 6);
			repeat (m) begin
				@(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		words_sent   = 0;
		results_seen = 0;
		frames_sent  = 0;
		reg_writes   = 0;
		mismatches   = 0;
		quiet_cycles = 0;
		break_case   = BREAK_OVERSIZE;
		clear_deframe_state();

		// reset held at the start, released on a falling edge, away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_frames();
		test_byte_extremes();
		test_max_handles();
		test_register_extremes();
		test_random_frames();
		test_sticky_error();

		// all predictions out, then watch for stray words
		go_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb_top: %0d words sent, %0d frames, %0d results checked, %0d register writes",
			words_sent, frames_sent, results_seen, reg_writes);
		$display("tb_top: run closed with %s, %0d mismatches", break_case.name(), mismatches);
		if (mismatches == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
